FILE: hdl/lkvc_pkg.sv
package lkvc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_MN_RD,
    ST_MN_WAIT,
    ST_MN_WR,
    ST_EVICT_RD,
    ST_EVICT_WAIT,
    ST_FREE,
    ST_INSERT,
    ST_RESULT
  } state_t;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam int CfgAddrBits = 3;
  localparam logic [CfgAddrBits-1:0] REG_CAPACITY = 3'd0;

endpackage

FILE: hdl/lru_key_value_cache.sv
// Operation: accepts a beat, reads one key slot per cycle and decides, then
//   relinks, evicts, inserts or presents the result.
// Beats are taken one at a time, the next only once the last has finished;
//   a result waiting on out_tready holds off the next beat.
// Reset: synchronous, active low; valid bits, fill count, list ends and capacity are
//   cleared or set at once, with no clearing pass.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tuser,   // [0] cmd
  input  logic [63:0] in_tdata,   // [31:0] lookup_key, [63:32] store_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tuser,  // [0] hit
  output logic [31:0] out_tdata,  // [31:0] read_value
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [lkvc_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CB = $clog2(MAX_ENTRIES + 1);
  localparam int KB = KEY_BITS;

  // memories
  logic [KB-1:0] key_mem   [MAX_ENTRIES];
  logic [31:0]   val_mem   [MAX_ENTRIES];
  logic [SB-1:0] newer_mem [MAX_ENTRIES];
  logic [SB-1:0] older_mem [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [SB-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [CB-1:0] used_r, used_nxt;
  logic [4:0]    cap_r;

  lkvc_pkg::state_t state_r, state_nxt;
  logic [SB:0]   idx_r, idx_nxt;      // scan counter, one beyond depth
  logic [SB-1:0] slot_r, slot_nxt;
  logic          found_r, found_nxt;
  logic          cmd_r;
  logic [KB-1:0] key_r;
  logic [31:0]   sval_r;
  logic          hit_r, hit_nxt;
  logic [31:0]   rval_r, rval_nxt;
  logic [SB-1:0] nw_r, od_r;

  // read ports, registered
  logic [KB-1:0] key_rd_r;
  logic [31:0]   val_rd_r;
  logic [SB-1:0] newer_rd_r, older_rd_r;
  logic [SB-1:0] rd_addr, rd_slot_r;
  logic          rd_v_r;

  // write strobes
  logic          key_we, val_we;
  logic [SB-1:0] lnk_wa1, lnk_wa2;
  logic          newer_we, older_we;
  logic [SB-1:0] newer_wa, newer_wd, older_wa, older_wd;
  logic          newer_we2, older_we2;
  logic [SB-1:0] newer_wa2, newer_wd2, older_wa2, older_wd2;

  logic [CB-1:0] eff_cap;
  logic [SB-1:0] free_slot;
  logic          in_acc;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == lkvc_pkg::ST_IDLE);
  assign out_tvalid = (state_r == lkvc_pkg::ST_RESULT);
  assign out_tuser  = {7'd0, hit_r};
  assign out_tdata  = rval_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == lkvc_pkg::REG_CAPACITY) ? {27'd0, cap_r} : 32'd0;

  // clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    if (cap_r == 5'd0) eff_cap = CB'(1);
    else if (32'(cap_r) > MAX_ENTRIES) eff_cap = CB'(MAX_ENTRIES);
    else eff_cap = CB'(cap_r);
  end

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_nxt[i]) free_slot = SB'(i);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 5'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == lkvc_pkg::REG_CAPACITY) begin
      cap_r <= cfg_pwdata[4:0];
    end
  end

  // memory reads
  assign rd_addr = (state_r == lkvc_pkg::ST_SCAN) ? idx_r[SB-1:0] : slot_r;
  always_ff @(posedge clk) begin
    key_rd_r   <= key_mem[rd_addr];
    val_rd_r   <= val_mem[rd_addr];
    newer_rd_r <= newer_mem[rd_addr];
    older_rd_r <= older_mem[rd_addr];
    rd_slot_r  <= rd_addr;
    rd_v_r     <= (state_r == lkvc_pkg::ST_SCAN);
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot_r] <= key_r;
    if (val_we) val_mem[slot_r] <= sval_r;
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (newer_we2) newer_mem[newer_wa2] <= newer_wd2;
    if (older_we) older_mem[older_wa] <= older_wd;
    if (older_we2) older_mem[older_wa2] <= older_wd2;
  end
  assign lnk_wa1 = newest_r;
  assign lnk_wa2 = od_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkvc_pkg::ST_IDLE:       if (in_acc) state_nxt = lkvc_pkg::ST_SCAN;
      lkvc_pkg::ST_SCAN:
        if (32'(idx_r) == MAX_ENTRIES - 1) state_nxt = lkvc_pkg::ST_SCAN_WAIT;
      lkvc_pkg::ST_SCAN_WAIT:  state_nxt = lkvc_pkg::ST_DECIDE;
      lkvc_pkg::ST_DECIDE: begin
        if (found_r) state_nxt = lkvc_pkg::ST_MN_RD;
        else if (cmd_r == lkvc_pkg::CMD_GET) state_nxt = lkvc_pkg::ST_RESULT;
        else if (used_r >= eff_cap) state_nxt = lkvc_pkg::ST_EVICT_RD;
        else state_nxt = lkvc_pkg::ST_FREE;
      end
      lkvc_pkg::ST_MN_RD:      state_nxt = lkvc_pkg::ST_MN_WAIT;
      lkvc_pkg::ST_MN_WAIT:    state_nxt = lkvc_pkg::ST_MN_WR;
      lkvc_pkg::ST_MN_WR:
        state_nxt = (cmd_r == lkvc_pkg::CMD_GET) ? lkvc_pkg::ST_RESULT : lkvc_pkg::ST_IDLE;
      lkvc_pkg::ST_EVICT_RD:   state_nxt = lkvc_pkg::ST_EVICT_WAIT;
      lkvc_pkg::ST_EVICT_WAIT: state_nxt = lkvc_pkg::ST_FREE;
      lkvc_pkg::ST_FREE:       state_nxt = lkvc_pkg::ST_INSERT;
      lkvc_pkg::ST_INSERT:     state_nxt = lkvc_pkg::ST_IDLE;
      lkvc_pkg::ST_RESULT:     if (out_tready) state_nxt = lkvc_pkg::ST_IDLE;
      default:                 state_nxt = lkvc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    rval_nxt   = rval_r;
    valid_nxt  = valid_r;
    newest_nxt = newest_r;
    oldest_nxt = oldest_r;
    used_nxt   = used_r;
    key_we = 1'b0;
    val_we = 1'b0;
    newer_we = 1'b0; newer_wa = '0; newer_wd = '0;
    older_we = 1'b0; older_wa = '0; older_wd = '0;
    newer_we2 = 1'b0; newer_wa2 = '0; newer_wd2 = '0;
    older_we2 = 1'b0; older_wa2 = '0; older_wd2 = '0;
    unique case (state_r)
      lkvc_pkg::ST_IDLE: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      lkvc_pkg::ST_SCAN: idx_nxt = idx_r + 1'b1;
      default: ;
    endcase
    // compare a slot's key in the cycle after its read
    if (rd_v_r && !found_r && valid_r[rd_slot_r] && key_rd_r == key_r) begin
      found_nxt = 1'b1;
      slot_nxt  = rd_slot_r;
    end
    unique case (state_r)
      lkvc_pkg::ST_DECIDE: begin
        hit_nxt  = found_r;
        rval_nxt = lkvc_pkg::MISS_VALUE;
        if (found_r && cmd_r == lkvc_pkg::CMD_PUT) val_we = 1'b1;
        if (!found_r) slot_nxt = oldest_r;
      end
      lkvc_pkg::ST_MN_WAIT: begin
        rval_nxt = val_rd_r;
      end
      lkvc_pkg::ST_MN_WR: begin
        // unlink slot and relink as newest
        if (slot_r != newest_r) begin
          older_we = 1'b1; older_wa = nw_r; older_wd = od_r;
          if (slot_r == oldest_r) oldest_nxt = nw_r;
          else begin
            newer_we = 1'b1; newer_wa = lnk_wa2; newer_wd = nw_r;
          end
          older_we2 = 1'b1; older_wa2 = slot_r; older_wd2 = newest_r;
          newer_we2 = 1'b1; newer_wa2 = lnk_wa1; newer_wd2 = slot_r;
          newest_nxt = slot_r;
        end
      end
      lkvc_pkg::ST_EVICT_WAIT: begin
        if (used_r > CB'(1)) oldest_nxt = newer_rd_r;
        valid_nxt[oldest_r] = 1'b0;
        used_nxt = used_r - 1'b1;
      end
      lkvc_pkg::ST_FREE: slot_nxt = free_slot;
      lkvc_pkg::ST_INSERT: begin
        key_we = 1'b1;
        val_we = 1'b1;
        valid_nxt[slot_r] = 1'b1;
        used_nxt = used_r + 1'b1;
        if (used_r == '0) begin
          newest_nxt = slot_r;
          oldest_nxt = slot_r;
        end else begin
          older_we = 1'b1; older_wa = slot_r; older_wd = newest_r;
          newer_we = 1'b1; newer_wa = lnk_wa1; newer_wd = slot_r;
          newest_nxt = slot_r;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lkvc_pkg::ST_IDLE;
      valid_r  <= '0;
      newest_r <= '0;
      oldest_r <= '0;
      used_r   <= '0;
      found_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      used_r   <= used_nxt;
      found_r  <= found_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // payload, captured links of the slot being moved
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    hit_r  <= hit_nxt;
    rval_r <= rval_nxt;
    if (in_acc) begin
      cmd_r  <= in_tuser[0];
      // sign-extend the 32-bit key, then keep KEY_BITS bits
      key_r  <= KB'($signed(in_tdata[31:0]));
      sval_r <= in_tdata[63:32];
    end
    if (state_r == lkvc_pkg::ST_MN_WAIT) begin
      nw_r <= newer_rd_r;
      od_r <= older_rd_r;
    end
  end

endmodule

FILE: tb/sv/tb.sv
module tb;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tuser = '0;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tuser;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [lkvc_pkg::CfgAddrBits-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // cache mirror: same slot layout and recency links as the block
  logic [31:0] mir_key [SLOTS];
  logic [31:0] mir_val [SLOTS];
  logic        mir_valid [SLOTS];
  logic [3:0]  mir_newer [SLOTS];
  logic [3:0]  mir_older [SLOTS];
  logic [3:0]  mir_newest, mir_oldest;
  int          mir_used;
  logic [4:0]  mir_capacity;

  lookup_result_t pending_lookups[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] recent_keys[$];

  lru_key_value_cache u_dut (.*);

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void mirror_reset();
    for (int i = 0; i < SLOTS; i++) begin
      mir_valid[i] = 1'b0;
      mir_newer[i] = '0;
      mir_older[i] = '0;
      mir_key[i] = '0;
      mir_val[i] = '0;
    end
    mir_newest = '0;
    mir_oldest = '0;
    mir_used = 0;
    mir_capacity = 5'd16;
  endfunction

  function automatic void promote_slot(input logic [3:0] s);
    logic [3:0] nw, od;
    if (s == mir_newest) return;
    nw = mir_newer[s];
    od = mir_older[s];
    mir_older[nw] = od;
    if (s == mir_oldest) mir_oldest = nw;
    else mir_newer[od] = nw;
    mir_older[s] = mir_newest;
    mir_newer[mir_newest] = s;
    mir_newest = s;
  endfunction

  // apply one command; push the expected lookup result for a get
  function automatic void predict_command(input logic cmd, input logic [31:0] key,
                                          input logic [31:0] val);
    int slot, cap;
    lookup_result_t r;
    logic [3:0] s;
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && mir_valid[i] && mir_key[i] == key) slot = i;
    if (cmd == lkvc_pkg::CMD_GET) begin
      if (slot >= 0) begin
        promote_slot(slot[3:0]);
        r.hit = 1'b1;
        r.value = mir_val[slot];
      end else begin
        r.hit = 1'b0;
        r.value = lkvc_pkg::MISS_VALUE;
      end
      pending_lookups.push_back(r);
      return;
    end
    if (slot >= 0) begin
      mir_val[slot] = val;
      promote_slot(slot[3:0]);
      return;
    end
    cap = (mir_capacity == 0) ? 1 : (mir_capacity > SLOTS ? SLOTS : mir_capacity);
    // evict the least recent entry when full
    if (mir_used >= cap && mir_used > 0) begin
      s = mir_oldest;
      if (mir_used > 1) mir_oldest = mir_newer[s];
      mir_valid[s] = 1'b0;
      mir_used--;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!mir_valid[i]) begin
        mir_key[i] = key;
        mir_val[i] = val;
        mir_valid[i] = 1'b1;
        if (mir_used == 0) begin
          mir_newest = i[3:0];
          mir_oldest = i[3:0];
        end else begin
          mir_older[i] = mir_newest;
          mir_newer[mir_newest] = i[3:0];
          mir_newest = i[3:0];
        end
        mir_used++;
        break;
      end
    end
  endfunction

  // send one beat, honoring the sender idle rate; valid drops only while idling
  task automatic send_command(input logic cmd, input logic [31:0] key,
                              input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {7'd0, cmd};
    in_tdata <= {val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_command(cmd, key, val);
  endtask

  // receiver: random stall and checking of each result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          lookup_result_t e;
          e = pending_lookups.pop_front();
          if (out_tuser[0] !== e.hit)
            report_mismatch($sformatf("hit %b expected %b", out_tuser[0], e.hit));
          if (out_tdata !== e.value)
            report_mismatch($sformatf("read_value %h expected %h", out_tdata, e.value));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    // a trailing put may still be relinking
    repeat (30) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= lkvc_pkg::REG_CAPACITY;
    cfg_pwdata <= {27'd0, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mir_capacity = cap;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (recent_keys.size() > 0 && $urandom_range(3) != 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    return (($urandom_range(3) == 0) ? $urandom() : $urandom_range(40)) ^
           ($urandom_range(1) ? 32'h8000_0000 : 32'h0);
  endfunction

  task automatic test_directed();
    send_command(lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    send_command(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_command(lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_command(lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    send_command(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'h1234_5678, 32'h0);
    drain();
    // capacity of one: each new put evicts the previous entry
    write_capacity(5'd1);
    send_command(lkvc_pkg::CMD_PUT, 32'd5, 32'd50);
    send_command(lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'd5, 32'h0);
    drain();
    // capacity zero acts as one; above the slot count saturates
    write_capacity(5'd0);
    send_command(lkvc_pkg::CMD_PUT, 32'd6, 32'd60);
    send_command(lkvc_pkg::CMD_GET, 32'd5, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'd6, 32'h0);
    drain();
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_command(lkvc_pkg::CMD_PUT, i, ~i);
    send_command(lkvc_pkg::CMD_GET, 32'd6, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'd17, 32'h0);
    drain();
    // lower capacity below the fill
    write_capacity(5'd4);
    send_command(lkvc_pkg::CMD_PUT, 32'd100, 32'd1);
    send_command(lkvc_pkg::CMD_GET, 32'd2, 32'h0);
    send_command(lkvc_pkg::CMD_GET, 32'd3, 32'h0);
    drain();
  endtask

  task automatic test_random(input int count, input logic [4:0] cap);
    logic [31:0] k;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      k = pick_key();
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
      recent_keys.push_back(k);
      send_command($urandom_range(1), k, $urandom());
    end
    drain();
  endtask

  initial begin
    mirror_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(160, 5'd16);
    send_idle_pct = 56; recv_stall_pct = 0;  test_random(160, 5'd3);
    send_idle_pct = 0;  recv_stall_pct = 56; test_random(160, 5'd8);
    send_idle_pct = 30; recv_stall_pct = 30; test_random(160, 5'd1);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(130, 5'd12);
    send_idle_pct = 30; recv_stall_pct = 56; test_random(130, 5'd16);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lkvc_pkg.sv
hdl/lru_key_value_cache.sv
tb/sv/tb.sv
